@@ sv/tbg_pkg.sv @@
// ----------------------------------------------------------------------------
// tbg_pkg
// Shared types, register codes and helpers for the broadcast gather block.
// ----------------------------------------------------------------------------
package tbg_pkg;

  localparam int NUM_SIZE_REGS = 4;
  localparam int SIZE_W        = 9;
  localparam int CNT_W         = 8;
  localparam int MASK_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 9;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE0 = 3'd0,
    REG_SIZE1 = 3'd1,
    REG_SIZE2 = 3'd2,
    REG_SIZE3 = 3'd3,
    REG_MASK  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0] size_vec_t;

  typedef struct packed {
    logic busy;
    logic at_end;
  } walk_stat_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_MAX) begin
      r = SIZE_MAX;
    end
    return r;
  endfunction

endpackage

@@ sv/tbg_ram.sv @@
// ----------------------------------------------------------------------------
// tbg_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tbg_walk.sv @@
// ----------------------------------------------------------------------------
// tbg_walk
// Per-axis output counters with incremental gather offset. Keeps a running
// base offset and a stride per axis; a rebuild pass recomputes both from the
// sizes and counters after every configuration write.
// ----------------------------------------------------------------------------
module tbg_walk #(
  parameter int MAX_AXES = 4
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  tbg_pkg::size_vec_t                         size_vec,
  input  logic [tbg_pkg::MASK_W-1:0]                 mask,
  input  logic                                       cfg_wr,
  input  logic                                       step,
  output logic [tbg_pkg::CNT_W*MAX_AXES-1:0]         off,
  output tbg_pkg::walk_stat_t                        stat
);

  localparam int OFF_W = tbg_pkg::CNT_W * MAX_AXES;
  localparam int AXW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int CNT_W = tbg_pkg::CNT_W;
  localparam int SIZE_W = tbg_pkg::SIZE_W;

  typedef enum logic [1:0] {
    RC_IDLE,
    RC_MUL,
    RC_ADD,
    RC_FIN
  } rc_state_t;

  logic [MAX_AXES-1:0][SIZE_W-1:0] sz;
  logic [MAX_AXES-1:0]             bc;
  logic [MAX_AXES-1:0]             run;

  logic [MAX_AXES-1:0][CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MAX_AXES-1:0][OFF_W-1:0]  base_r, base_nxt;
  logic [MAX_AXES-1:0][OFF_W-1:0]  strd_r;
  logic [MAX_AXES-1:0][OFF_W-1:0]  sfx_r;
  rc_state_t                       rc_r;
  logic [AXW-1:0]                  ax_r;
  logic [OFF_W-1:0]                acc_r;
  logic [OFF_W-1:0]                prod_r;
  logic [OFF_W-1:0]                mstr_r;

  logic                            step_done;
  logic [AXW-1:0]                  step_sel;
  logic [OFF_W-1:0]                step_base;
  logic [OFF_W+CNT_W-1:0]          mul_cnt;
  logic [OFF_W+SIZE_W-1:0]         mul_str;
  logic [OFF_W-1:0]                acc_sum;

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_axis
    if (g < tbg_pkg::NUM_SIZE_REGS) begin : g_reg
      assign sz[g] = tbg_pkg::eff_size(size_vec[g]);
      assign bc[g] = mask[g];
    end else begin : g_pad
      assign sz[g] = SIZE_W'(1);
      assign bc[g] = 1'b1;
    end
    assign run[g] = (SIZE_W'(cnt_r[g]) + SIZE_W'(1)) < sz[g];
  end

  // advance: innermost axis with room counts up, inner ones wrap; all rewind at the end
  always_comb begin
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    step_done = 1'b0;
    step_sel  = '0;
    for (int a = MAX_AXES - 1; a >= 0; a--) begin
      if (!step_done) begin
        if (run[a]) begin
          cnt_nxt[a] = cnt_r[a] + CNT_W'(1);
          step_sel   = AXW'(a);
          step_done  = 1'b1;
        end else begin
          cnt_nxt[a] = '0;
        end
      end
    end
    step_base = bc[step_sel] ? base_r[step_sel] : base_r[step_sel] + strd_r[step_sel];
    for (int b = 0; b < MAX_AXES; b++) begin
      if (b >= int'(step_sel)) begin
        base_nxt[b] = step_base;
      end
    end
    if (!step_done) begin
      cnt_nxt  = '0;
      base_nxt = '0;
    end
  end

  assign mul_cnt = cnt_r[ax_r] * mstr_r;
  assign mul_str = sz[ax_r] * mstr_r;
  assign acc_sum = acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= RC_IDLE;
      ax_r   <= '0;
      cnt_r  <= '0;
      base_r <= '0;
      for (int a = 0; a < MAX_AXES; a++) begin
        strd_r[a] <= OFF_W'(1);
      end
    end else begin
      if (step) begin
        cnt_r  <= cnt_nxt;
        base_r <= base_nxt;
      end
      case (rc_r)
        RC_IDLE: begin
        end
        RC_MUL: begin
          strd_r[ax_r] <= mstr_r;
          prod_r       <= bc[ax_r] ? '0 : mul_cnt[OFF_W-1:0];
          if (!bc[ax_r]) begin
            mstr_r <= mul_str[OFF_W-1:0];
          end
          rc_r <= RC_ADD;
        end
        RC_ADD: begin
          acc_r       <= acc_sum;
          sfx_r[ax_r] <= acc_sum;
          if (ax_r == '0) begin
            rc_r <= RC_FIN;
          end else begin
            ax_r <= ax_r - AXW'(1);
            rc_r <= RC_MUL;
          end
        end
        RC_FIN: begin
          for (int a = 0; a < MAX_AXES - 1; a++) begin
            base_r[a] <= sfx_r[0] - sfx_r[a+1];
          end
          base_r[MAX_AXES-1] <= sfx_r[0];
          rc_r <= RC_IDLE;
        end
        default: begin
          rc_r <= RC_IDLE;
        end
      endcase
      if (cfg_wr) begin
        rc_r   <= RC_MUL;
        ax_r   <= AXW'(MAX_AXES - 1);
        acc_r  <= '0;
        mstr_r <= OFF_W'(1);
      end
    end
  end

  assign off         = base_r[MAX_AXES-1];
  assign stat.busy   = (rc_r != RC_IDLE);
  assign stat.at_end = !step_done;

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> stat.busy)
    else $error("rebuild not started after config write");

  a_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !stat.busy)
    else $error("step taken during rebuild");

  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (step && stat.at_end && !cfg_wr) |=> (off == '0) && (cnt_r == '0))
    else $error("walk did not rewind on last element");

endmodule

@@ sv/tensor_broadcast_gather_top.sv @@
// ----------------------------------------------------------------------------
// tensor_broadcast_gather_top
// Broadcasts a tensor of up to MAX_AXES axes to a larger output shape.
// Load beats (op 0) write input elements in row-major order into the element
// RAM; emit beats (op 1) return the next output element in row-major order,
// gathered with zero stride on broadcast axes, and last marks the final one.
// Loads and emits alike are accepted at one item per cycle while the output
// side keeps taking results and no rebuild runs; an emit's RAM read lands in
// the read stage, and its result then moves into the output register. After
// each configuration write the per-axis strides and offsets are rebuilt from
// the sizes and counters by a sequential pass, during which input is stalled.
// Loads past STORE_DEPTH are dropped; a gather beyond STORE_DEPTH returns zero.
// No clearing pass: RAM entries are meaningful only once loaded.
// ----------------------------------------------------------------------------
module tensor_broadcast_gather_top #(
  parameter int MAX_AXES    = 4,
  parameter int STORE_DEPTH = 4096,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [DATA_WIDTH-1:0]            in_load_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [DATA_WIDTH-1:0]            out_value,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int LP_W  = $clog2(STORE_DEPTH + 1);
  localparam int OFF_W = tbg_pkg::CNT_W * MAX_AXES;
  localparam int CW    = (OFF_W > LP_W) ? OFF_W : LP_W;

  tbg_pkg::size_vec_t             size_r;
  logic [tbg_pkg::MASK_W-1:0]     mask_r;
  logic [LP_W-1:0]                lp_r;
  logic                           p1_valid_r;
  logic                           p1_last_r;
  logic                           p1_oob_r;
  logic                           out_valid_r;
  logic [DATA_WIDTH-1:0]          out_value_r;
  logic                           out_last_r;

  logic                           cfg_wr;
  logic                           in_acc;
  logic                           do_load;
  logic                           do_emit;
  logic                           out_adv;
  logic                           lp_room;
  logic                           in_range;
  logic [OFF_W-1:0]               off;
  logic [CW-1:0]                  off_ext;
  tbg_pkg::walk_stat_t            wstat;
  logic [DATA_WIDTH-1:0]          rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = wstat.busy || (p1_valid_r && !out_adv);
  assign in_acc   = in_valid && !in_stall;
  assign do_load  = in_acc && (in_op == tbg_pkg::OP_LOAD);
  assign do_emit  = in_acc && (in_op == tbg_pkg::OP_EMIT);

  assign lp_room  = lp_r < LP_W'(STORE_DEPTH);
  assign off_ext  = CW'(off);
  assign in_range = off_ext < CW'(STORE_DEPTH);

  tbg_walk #(
    .MAX_AXES (MAX_AXES)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .size_vec (size_r),
    .mask     (mask_r),
    .cfg_wr   (cfg_wr),
    .step     (do_emit),
    .off      (off),
    .stat     (wstat)
  );

  tbg_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_load && lp_room),
    .waddr (lp_r[AW-1:0]),
    .wdata (in_load_value),
    .re    (do_emit && in_range),
    .raddr (off_ext[AW-1:0]),
    .rdata (rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < tbg_pkg::NUM_SIZE_REGS; a++) begin
        size_r[a] <= tbg_pkg::SIZE_W'(1);
      end
      mask_r <= '0;
    end else if (cfg_wr) begin
      case (tbg_pkg::cfg_reg_t'(cfg_index))
        tbg_pkg::REG_SIZE0: size_r[0] <= cfg_data;
        tbg_pkg::REG_SIZE1: size_r[1] <= cfg_data;
        tbg_pkg::REG_SIZE2: size_r[2] <= cfg_data;
        tbg_pkg::REG_SIZE3: size_r[3] <= cfg_data;
        tbg_pkg::REG_MASK:  mask_r    <= cfg_data[tbg_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // load pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
    end else if (do_emit && wstat.at_end) begin
      lp_r <= '0;
    end else if (do_load && lp_room) begin
      lp_r <= lp_r + LP_W'(1);
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_emit) begin
        p1_valid_r <= 1'b1;
        p1_last_r  <= wstat.at_end;
        p1_oob_r   <= !in_range;
      end else if (out_adv) begin
        p1_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= p1_valid_r;
        if (p1_valid_r) begin
          out_value_r <= p1_oob_r ? '0 : rdata;
          out_last_r  <= p1_last_r;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  a_lp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lp_r <= LP_W'(STORE_DEPTH))
    else $error("load pointer past store depth");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p1_valid_r))
    else $error("result beat without a read behind it");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && !out_adv) |=> p1_valid_r && $stable(p1_last_r) && $stable(rdata))
    else $error("pending read lost while output blocked");

endmodule
